// File: sv/kstc_pkg.sv
`default_nettype none
package kstc_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int KEY_COUNT  = 128;
	localparam int KEY_W      = $clog2(KEY_COUNT);
	localparam int OUT_DEPTH  = 4;
	localparam int OQ_AW      = $clog2(OUT_DEPTH);
	localparam int OQ_CW      = $clog2(OUT_DEPTH + 2);
	localparam int OPQ_DEPTH  = 2;

	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_MAP  = 2'd2;

	localparam logic [KEY_W-1:0] KEY_SHIFT_A = KEY_W'(42);
	localparam logic [KEY_W-1:0] KEY_SHIFT_B = KEY_W'(54);
	localparam logic [KEY_W-1:0] KEY_CAPS    = KEY_W'(58);
	localparam logic [KEY_W-1:0] KEY_NUM     = KEY_W'(69);
	localparam logic [KEY_W-1:0] KEY_SCROLL  = KEY_W'(70);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] scan_byte;
		logic [7:0] status_byte;
		logic [6:0] map_key;
		logic       map_shifted;
		logic [7:0] map_char;
	} in_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_code;
		logic       fifo_empty;
		logic       char_dropped;
		logic       leds_changed;
		logic [2:0] led_bits;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PRESS,
		OP_RELEASE,
		OP_READ
	} op_e;

	typedef struct packed {
		op_e              op;
		logic [KEY_W-1:0] key;
		logic [7:0]       plain_char;
		logic [7:0]       shift_char;
	} op_t;

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
		return (p == RING_LAST) ? '0 : RING_AW'(p + 1'b1);
	endfunction

endpackage
`default_nettype wire

// File: sv/kstc_front.sv
`default_nettype none
module kstc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire kstc_pkg::in_item_t  item,
	input  wire logic                q_ready,
	output logic                     q_push,
	output kstc_pkg::op_t            q_op
);

	logic [7:0] plain_mem [kstc_pkg::KEY_COUNT];
	logic [7:0] shift_mem [kstc_pkg::KEY_COUNT];
	logic [kstc_pkg::KEY_COUNT-1:0] plain_vld_q;
	logic [kstc_pkg::KEY_COUNT-1:0] shift_vld_q;

	logic                       s1_valid_q;
	kstc_pkg::op_e              op_s1;
	logic [kstc_pkg::KEY_W-1:0] key_s1;
	logic [7:0]                 plain_rd_s1;
	logic [7:0]                 shift_rd_s1;
	logic                       plain_ok_s1;
	logic                       shift_ok_s1;

	logic                       advance;
	logic                       accept;
	logic                       map_wr;
	kstc_pkg::op_e              op_dec;
	logic [kstc_pkg::KEY_W-1:0] key_dec;

	assign advance = !s1_valid_q || q_ready;
	assign full    = !advance;
	assign accept  = push && advance;
	assign map_wr  = accept && (item.kind == kstc_pkg::KIND_MAP);
	assign key_dec = item.scan_byte[kstc_pkg::KEY_W-1:0];

	always_comb begin
		case (item.kind)
			kstc_pkg::KIND_SCAN: begin
				if (item.status_byte == 8'd0)
					op_dec = kstc_pkg::OP_NONE;
				else if (item.scan_byte[7])
					op_dec = kstc_pkg::OP_RELEASE;
				else
					op_dec = kstc_pkg::OP_PRESS;
			end
			kstc_pkg::KIND_READ: op_dec = kstc_pkg::OP_READ;
			default:             op_dec = kstc_pkg::OP_NONE;
		endcase
	end

	// keymaps: written and looked up in item order
	always_ff @(posedge clk) begin
		if (map_wr && item.map_shifted)
			shift_mem[item.map_key] <= item.map_char;
		if (map_wr && !item.map_shifted)
			plain_mem[item.map_key] <= item.map_char;
		if (accept) begin
			plain_rd_s1 <= plain_mem[key_dec];
			shift_rd_s1 <= shift_mem[key_dec];
			plain_ok_s1 <= plain_vld_q[key_dec];
			shift_ok_s1 <= shift_vld_q[key_dec];
			op_s1       <= op_dec;
			key_s1      <= key_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_vld_q <= '0;
			shift_vld_q <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (map_wr && item.map_shifted)
				shift_vld_q[item.map_key] <= 1'b1;
			if (map_wr && !item.map_shifted)
				plain_vld_q[item.map_key] <= 1'b1;
			if (advance)
				s1_valid_q <= push;
		end
	end

	assign q_push          = s1_valid_q && q_ready;
	assign q_op.op         = op_s1;
	assign q_op.key        = key_s1;
	assign q_op.plain_char = plain_ok_s1 ? plain_rd_s1 : 8'd0;
	assign q_op.shift_char = shift_ok_s1 ? shift_rd_s1 : 8'd0;

endmodule
`default_nettype wire

// File: sv/kstc_opq.sv
`default_nettype none
module kstc_opq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire kstc_pkg::op_t  wr_op,
	output logic                ready,
	output logic                valid,
	input  wire logic           rd_en,
	output kstc_pkg::op_t       rd_op
);

	localparam int AW = $clog2(kstc_pkg::OPQ_DEPTH);

	kstc_pkg::op_t  ent_q [kstc_pkg::OPQ_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign ready = (cnt_q != (AW+1)'(kstc_pkg::OPQ_DEPTH));
	assign valid = (cnt_q != '0);
	assign do_wr = wr_en && ready;
	assign do_rd = rd_en && valid;
	assign rd_op = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_q <= (wr_q == AW'(kstc_pkg::OPQ_DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);
			if (do_rd)
				rd_q <= (rd_q == AW'(kstc_pkg::OPQ_DEPTH - 1)) ? '0 : AW'(rd_q + 1'b1);
			if (do_wr && !do_rd)
				cnt_q <= (AW+1)'(cnt_q + 1'b1);
			else if (do_rd && !do_wr)
				cnt_q <= (AW+1)'(cnt_q - 1'b1);
		end
	end

endmodule
`default_nettype wire

// File: sv/kstc_back.sv
`default_nettype none
module kstc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire kstc_pkg::op_t  q_op,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output kstc_pkg::out_item_t rsp
);

	logic [7:0] ring_mem [kstc_pkg::RING_DEPTH];

	logic [kstc_pkg::KEY_COUNT-1:0] key_down_q;
	logic                           caps_q;
	logic                           num_q;
	logic                           scroll_q;
	logic [kstc_pkg::RING_AW-1:0]   rptr_q;
	logic [kstc_pkg::RING_AW-1:0]   wptr_q;

	logic                           s2_valid_q;
	kstc_pkg::out_item_t            res_s2;
	logic [7:0]                     ring_rd_s2;

	kstc_pkg::out_item_t            oq_q [kstc_pkg::OUT_DEPTH];
	logic [kstc_pkg::OQ_AW-1:0]     oq_wr_q;
	logic [kstc_pkg::OQ_AW-1:0]     oq_rd_q;
	logic [kstc_pkg::OQ_CW-1:0]     ocnt_q;

	logic                         fire;
	logic                         is_press;
	logic                         fresh;
	logic                         caps_n;
	logic                         num_n;
	logic                         scroll_n;
	logic                         toggled;
	logic                         shifted;
	logic [7:0]                   ch;
	logic                         push_try;
	logic                         ring_wr;
	logic                         dropped;
	logic                         rd_en;
	logic [kstc_pkg::RING_AW-1:0] wnext;
	logic [kstc_pkg::RING_AW-1:0] rnext;
	logic [kstc_pkg::RING_AW-1:0] rptr_n;
	logic [kstc_pkg::RING_AW-1:0] wptr_n;
	kstc_pkg::out_item_t          res_n;
	kstc_pkg::out_item_t          res_fin;
	logic                         oq_pop;
	logic [2:0]                   led_q;

	assign fire  = q_valid &&
		((ocnt_q + kstc_pkg::OQ_CW'(s2_valid_q)) < kstc_pkg::OQ_CW'(kstc_pkg::OUT_DEPTH));
	assign q_pop = fire;
	assign led_q = {caps_q, num_q, scroll_q};

	always_comb begin
		is_press = fire && (q_op.op == kstc_pkg::OP_PRESS);
		fresh    = is_press && !key_down_q[q_op.key];
		caps_n   = caps_q ^ (fresh && (q_op.key == kstc_pkg::KEY_CAPS));
		num_n    = num_q ^ (fresh && (q_op.key == kstc_pkg::KEY_NUM));
		scroll_n = scroll_q ^ (fresh && (q_op.key == kstc_pkg::KEY_SCROLL));
		toggled  = fresh && ((q_op.key == kstc_pkg::KEY_CAPS) ||
			(q_op.key == kstc_pkg::KEY_NUM) || (q_op.key == kstc_pkg::KEY_SCROLL));
		shifted  = caps_n || key_down_q[kstc_pkg::KEY_SHIFT_A] ||
			key_down_q[kstc_pkg::KEY_SHIFT_B];
		ch       = shifted ? q_op.shift_char : q_op.plain_char;
		wnext    = kstc_pkg::ring_next(wptr_q);
		rnext    = kstc_pkg::ring_next(rptr_q);
		push_try = is_press && (ch != 8'd0);
		ring_wr  = push_try && (wnext != rptr_q);
		dropped  = push_try && (wnext == rptr_q);
		rd_en    = fire && (q_op.op == kstc_pkg::OP_READ) && (rptr_q != wptr_q);
		rptr_n   = rd_en ? rnext : rptr_q;
		wptr_n   = ring_wr ? wnext : wptr_q;

		res_n.char_valid   = rd_en;
		res_n.char_code    = 8'd0;
		res_n.fifo_empty   = (rptr_n == wptr_n);
		res_n.char_dropped = dropped;
		res_n.leds_changed = toggled;
		res_n.led_bits     = {caps_n, num_n, scroll_n};
	end

	// ring never reads the slot written in the same cycle: a pop needs rptr != wptr
	always_ff @(posedge clk) begin
		if (ring_wr)
			ring_mem[wptr_q] <= ch;
		if (rd_en)
			ring_rd_s2 <= ring_mem[rptr_q];
		if (fire)
			res_s2 <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q <= '0;
			caps_q     <= 1'b0;
			num_q      <= 1'b0;
			scroll_q   <= 1'b0;
			rptr_q     <= '0;
			wptr_q     <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (fire && (q_op.op == kstc_pkg::OP_RELEASE))
				key_down_q[q_op.key] <= 1'b0;
			else if (is_press)
				key_down_q[q_op.key] <= 1'b1;
			caps_q     <= caps_n;
			num_q      <= num_n;
			scroll_q   <= scroll_n;
			rptr_q     <= rptr_n;
			wptr_q     <= wptr_n;
			s2_valid_q <= fire;
		end
	end

	always_comb begin
		res_fin           = res_s2;
		res_fin.char_code = res_s2.char_valid ? ring_rd_s2 : 8'd0;
	end

	// result queue, room is reserved at issue
	assign empty  = (ocnt_q == '0);
	assign oq_pop = pop && !empty;
	assign rsp    = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (s2_valid_q)
			oq_q[oq_wr_q] <= res_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (s2_valid_q)
				oq_wr_q <= (oq_wr_q == kstc_pkg::OQ_AW'(kstc_pkg::OUT_DEPTH - 1)) ?
					'0 : kstc_pkg::OQ_AW'(oq_wr_q + 1'b1);
			if (oq_pop)
				oq_rd_q <= (oq_rd_q == kstc_pkg::OQ_AW'(kstc_pkg::OUT_DEPTH - 1)) ?
					'0 : kstc_pkg::OQ_AW'(oq_rd_q + 1'b1);
			if (s2_valid_q && !oq_pop)
				ocnt_q <= kstc_pkg::OQ_CW'(ocnt_q + 1'b1);
			else if (oq_pop && !s2_valid_q)
				ocnt_q <= kstc_pkg::OQ_CW'(ocnt_q - 1'b1);
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= kstc_pkg::OQ_CW'(kstc_pkg::OUT_DEPTH))
		else $error("result queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && res_s2.char_valid |-> $past(rptr_q != wptr_q))
		else $error("character popped from empty ring");

	a_one_lock: assert property (@(posedge clk) disable iff (!arst_n)
		toggled |=> $countones(led_q ^ $past(led_q)) == 1)
		else $error("lock toggle changed other than one LED");

	a_no_drop_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> !(res_s2.char_valid && res_s2.char_dropped))
		else $error("read item flagged a drop");

endmodule
`default_nettype wire

// File: sv/keyboard_scancode_to_char_fifo_core.sv
// Set-1 keyboard decoder with a character ring. One item is accepted per
// clock while full is low; each item yields exactly one result, in order,
// on a queue-style output. The front stage looks up both keymaps (one
// registered read of each 128-entry map) and applies keymap writes; a
// two-entry op queue decouples it from the back end, which updates the
// key-down state, lock state and ring pointers and reads the 1024-entry
// ring through its registered port. A four-entry result queue keeps input
// flowing while results wait to be popped. No clearing pass runs after
// reset.
`default_nettype none
module keyboard_scancode_to_char_fifo_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire kstc_pkg::in_item_t  scan_item,
	output logic                     empty,
	input  wire logic                pop,
	output kstc_pkg::out_item_t      char_item
);

	logic          q_ready;
	logic          q_push;
	kstc_pkg::op_t q_wr_op;
	logic          q_valid;
	logic          q_pop;
	kstc_pkg::op_t q_rd_op;

	kstc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (scan_item),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_op    (q_wr_op)
	);

	kstc_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_op  (q_wr_op),
		.ready  (q_ready),
		.valid  (q_valid),
		.rd_en  (q_pop),
		.rd_op  (q_rd_op)
	);

	kstc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (q_rd_op),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.rsp     (char_item)
	);

endmodule
`default_nettype wire

// File: test/keyboard_scancode_to_char_fifo_core_tb.sv
`default_nettype none
module keyboard_scancode_to_char_fifo_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [kstc_pkg::KEY_W-1:0] KEY_A = kstc_pkg::KEY_W'(30);
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;

	class keystroke_scoreboard;
		bit [kstc_pkg::KEY_COUNT-1:0] key_down;
		bit caps_on, num_on, scroll_on;
		bit [7:0] plain_map [kstc_pkg::KEY_COUNT];
		bit [7:0] shift_map [kstc_pkg::KEY_COUNT];
		bit [7:0] ring_chars [$];
		kstc_pkg::out_item_t pending_outcomes [$];
		int errors, items, checked, pushed, dropped, toggles, empty_reads;

		function void note_item(kstc_pkg::in_item_t it);
			kstc_pkg::out_item_t r;
			logic [kstc_pkg::KEY_W-1:0] k;
			logic [7:0] ch;
			r = '0;
			items++;
			case (it.kind)
				kstc_pkg::KIND_SCAN: if (it.status_byte != 8'd0) begin
					k = it.scan_byte[6:0];
					if (it.scan_byte[7]) begin
						key_down[k] = 1'b0;
					end else begin
						if (!key_down[k]) begin
							if (k == kstc_pkg::KEY_CAPS) begin
								caps_on = !caps_on;
								r.leds_changed = 1'b1;
							end else if (k == kstc_pkg::KEY_NUM) begin
								num_on = !num_on;
								r.leds_changed = 1'b1;
							end else if (k == kstc_pkg::KEY_SCROLL) begin
								scroll_on = !scroll_on;
								r.leds_changed = 1'b1;
							end
						end
						if (caps_on || key_down[kstc_pkg::KEY_SHIFT_A] ||
							key_down[kstc_pkg::KEY_SHIFT_B])
							ch = shift_map[k];
						else
							ch = plain_map[k];
						if (ch != 8'd0) begin
							if (ring_chars.size() == kstc_pkg::RING_DEPTH - 1) begin
								r.char_dropped = 1'b1;
								dropped++;
							end else begin
								ring_chars.push_back(ch);
								pushed++;
							end
						end
						key_down[k] = 1'b1;
					end
				end
				kstc_pkg::KIND_READ: begin
					if (ring_chars.size() != 0) begin
						r.char_valid = 1'b1;
						r.char_code = ring_chars.pop_front();
					end else begin
						empty_reads++;
					end
				end
				kstc_pkg::KIND_MAP: begin
					if (it.map_shifted)
						shift_map[it.map_key] = it.map_char;
					else
						plain_map[it.map_key] = it.map_char;
				end
				default: ;
			endcase
			if (r.leds_changed)
				toggles++;
			r.fifo_empty = (ring_chars.size() == 0);
			r.led_bits = {caps_on, num_on, scroll_on};
			pending_outcomes.push_back(r);
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(kstc_pkg::out_item_t got);
			kstc_pkg::out_item_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			checked++;
			compare("char_valid", want.char_valid, got.char_valid);
			compare("char_code", want.char_code, got.char_code);
			compare("fifo_empty", want.fifo_empty, got.fifo_empty);
			compare("char_dropped", want.char_dropped, got.char_dropped);
			compare("leds_changed", want.leds_changed, got.leds_changed);
			compare("led_bits", want.led_bits, got.led_bits);
		endfunction

		function int pending_count();
			return pending_outcomes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	kstc_pkg::in_item_t scan_item;
	logic empty;
	logic pop;
	kstc_pkg::out_item_t char_item;

	keystroke_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int quiet_cycles = 0;
	int unsigned key_pool [$];

	keyboard_scancode_to_char_fifo_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.scan_item(scan_item),
		.empty(empty),
		.pop(pop),
		.char_item(char_item)
	);

	always #1 clk = ~clk;

	function automatic kstc_pkg::in_item_t scan_ev(logic [7:0] scan, logic [7:0] status);
		kstc_pkg::in_item_t it;
		it = '0;
		it.kind = kstc_pkg::KIND_SCAN;
		it.scan_byte = scan;
		it.status_byte = status;
		return it;
	endfunction

	function automatic kstc_pkg::in_item_t map_ev(logic [6:0] key, logic shifted,
		logic [7:0] ch);
		kstc_pkg::in_item_t it;
		it = '0;
		it.kind = kstc_pkg::KIND_MAP;
		it.map_key = key;
		it.map_shifted = shifted;
		it.map_char = ch;
		return it;
	endfunction

	function automatic kstc_pkg::in_item_t read_ev();
		kstc_pkg::in_item_t it;
		it = '0;
		it.kind = kstc_pkg::KIND_READ;
		return it;
	endfunction

	function automatic kstc_pkg::in_item_t random_keystroke(int read_pct);
		kstc_pkg::in_item_t it;
		int r;
		it.kind = 2'($urandom_range(3));
		it.scan_byte = 8'($urandom);
		it.status_byte = 8'($urandom);
		it.map_key = 7'($urandom);
		it.map_shifted = 1'($urandom);
		it.map_char = 8'($urandom);
		r = $urandom_range(99);
		if (r < 8)
			return it;
		if (r < 8 + read_pct) begin
			it.kind = kstc_pkg::KIND_READ;
		end else if (r < 14 + read_pct) begin
			it.kind = kstc_pkg::KIND_MAP;
			if ($urandom_range(4) == 0)
				it.map_char = 8'd0;
		end else begin
			it.kind = kstc_pkg::KIND_SCAN;
			it.status_byte = 8'($urandom_range(1, 255));
			if ($urandom_range(3) != 0)
				it.scan_byte[6:0] = 7'(key_pool[$urandom_range(key_pool.size() - 1)]);
			it.scan_byte[7] = ($urandom_range(99) < 35);
		end
		return it;
	endfunction

	task automatic send_item(kstc_pkg::in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		scan_item <= it;
		forever begin
			@(posedge clk);
			if (!full)
				break;
			stall_cycles++;
		end
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending_count() != 0)
			@(negedge clk);
	endtask

	// receiver
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check_outcome(char_item);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int unsigned fill_key;
		int drops_before;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		scan_item = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(read_ev());
		send_item(map_ev(KEY_A, 1'b0, 8'h61));
		send_item(map_ev(KEY_A, 1'b1, 8'h41));
		send_item(map_ev(7'd127, 1'b0, 8'hFF));
		send_item(map_ev(7'd0, 1'b1, 8'h01));
		send_item(scan_ev({1'b0, KEY_A}, 8'h00));
		send_item(scan_ev({1'b0, KEY_A}, 8'h01));
		send_item(scan_ev({1'b0, KEY_A}, 8'hFF));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_SHIFT_A}, 8'h80));
		send_item(scan_ev({1'b0, KEY_A}, 8'h01));
		send_item(scan_ev({1'b1, kstc_pkg::KEY_SHIFT_A}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_SHIFT_B}, 8'h01));
		send_item(scan_ev({1'b0, KEY_A}, 8'h01));
		send_item(scan_ev({1'b1, kstc_pkg::KEY_SHIFT_B}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_CAPS}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_CAPS}, 8'h01));
		send_item(scan_ev({1'b1, kstc_pkg::KEY_CAPS}, 8'h01));
		send_item(scan_ev({1'b0, KEY_A}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_NUM}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_SCROLL}, 8'h01));
		send_item(scan_ev({1'b0, kstc_pkg::KEY_CAPS}, 8'h01));
		send_item(scan_ev(8'h7F, 8'h01));
		send_item(scan_ev(8'hFF, 8'h01));
		send_item(scan_ev(8'h00, 8'h01));
		send_item({KIND_UNUSED, 32'hFFFF_FFFF});
		send_item(read_ev());
		wait_drained();

		key_pool.push_back(kstc_pkg::KEY_SHIFT_A);
		key_pool.push_back(kstc_pkg::KEY_SHIFT_B);
		key_pool.push_back(kstc_pkg::KEY_CAPS);
		key_pool.push_back(kstc_pkg::KEY_NUM);
		key_pool.push_back(kstc_pkg::KEY_SCROLL);
		repeat (16) key_pool.push_back($urandom_range(kstc_pkg::KEY_COUNT - 1));
		foreach (key_pool[i]) begin
			send_item(map_ev(7'(key_pool[i]), 1'b0, 8'($urandom_range(1, 255))));
			send_item(map_ev(7'(key_pool[i]), 1'b1, 8'($urandom_range(1, 255))));
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
				default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
			endcase
			repeat (40) send_item(random_keystroke(30));
			if (ph == 0) begin
				hold_request = 1'b1;
				repeat (20) send_item(random_keystroke(30));
				wait_drained();
				// fill the ring until a few chars are dropped, then read some back
				do fill_key = $urandom_range(kstc_pkg::KEY_COUNT - 1);
				while (fill_key inside {kstc_pkg::KEY_SHIFT_A, kstc_pkg::KEY_SHIFT_B,
					kstc_pkg::KEY_CAPS, kstc_pkg::KEY_NUM, kstc_pkg::KEY_SCROLL});
				send_item(map_ev(7'(fill_key), 1'b0, 8'($urandom_range(1, 255))));
				send_item(map_ev(7'(fill_key), 1'b1, 8'($urandom_range(1, 255))));
				drops_before = sb.dropped;
				while (sb.dropped < drops_before + 4)
					send_item(scan_ev({1'b0, 7'(fill_key)}, 8'($urandom_range(1, 255))));
				repeat (30) send_item(read_ev());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.pending_count() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending_count());
			sb.errors++;
		end
		$display("Sent %0d items, checked %0d results; %0d chars queued, %0d dropped on full.",
			sb.items, sb.checked, sb.pushed, sb.dropped);
		$display("Lock toggles %0d, empty reads %0d, input stall cycles %0d, errors %0d.",
			sb.toggles, sb.empty_reads, stall_cycles, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
